>>> hw/rtl/nearest_named_color_classifier_top_defines.svh
// Assertion macros shared by the nearest named color classifier RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef NEAREST_NAMED_COLOR_CLASSIFIER_TOP_DEFINES_SVH
`define NEAREST_NAMED_COLOR_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NNC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/nnc_pkg.sv
// Package for the nearest named color classifier: word types, codes, palette
// constants and the linearization table function. Depends on nothing.
`timescale 1ns / 1ps

package nnc_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       matched;
    logic [7:0] palette_index;
    logic [9:0] best_distance;
    logic [3:0] fallback_class;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       luma;
    logic [2:0] luma_cnt;
    logic       out_load;
  } nnc_cmd_t;

  typedef struct packed {
    logic scan_last;
  } nnc_status_t;

  localparam logic [1:0] REG_TOLERANCE = 2'd0;
  localparam logic [1:0] REG_WHITE     = 2'd1;
  localparam logic [1:0] REG_BLACK     = 2'd2;

  localparam logic [3:0] CLS_MATCHED      = 4'd0;
  localparam logic [3:0] CLS_WHITE        = 4'd1;
  localparam logic [3:0] CLS_BLACK        = 4'd2;
  localparam logic [3:0] CLS_STRONG_BASE  = 4'd3;
  localparam logic [3:0] CLS_FAMILY_BASE  = 4'd6;

  localparam logic [7:0]  TOLERANCE_RESET = 8'd26;
  localparam logic [15:0] WHITE_RESET     = 16'd55706;
  localparam logic [15:0] BLACK_RESET     = 16'd9830;

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam logic [2:0] LUMA_LAST = 3'd4;

  localparam int ROM_DEPTH = 141;

  localparam logic [23:0] PALETTE_ROM [ROM_DEPTH] = '{
    {8'd240,8'd248,8'd255}, {8'd250,8'd235,8'd215}, {8'd127,8'd255,8'd212},
    {8'd240,8'd255,8'd255}, {8'd245,8'd245,8'd220}, {8'd255,8'd228,8'd196},
    {8'd0,8'd0,8'd0},       {8'd255,8'd235,8'd205}, {8'd0,8'd0,8'd255},
    {8'd138,8'd43,8'd226},  {8'd165,8'd42,8'd42},   {8'd222,8'd184,8'd135},
    {8'd95,8'd158,8'd160},  {8'd127,8'd255,8'd0},   {8'd210,8'd105,8'd30},
    {8'd255,8'd127,8'd80},  {8'd100,8'd149,8'd237}, {8'd255,8'd248,8'd220},
    {8'd220,8'd20,8'd60},   {8'd0,8'd255,8'd255},   {8'd0,8'd0,8'd139},
    {8'd0,8'd139,8'd139},   {8'd184,8'd134,8'd11},  {8'd169,8'd169,8'd169},
    {8'd0,8'd100,8'd0},     {8'd189,8'd183,8'd107}, {8'd139,8'd0,8'd139},
    {8'd85,8'd107,8'd47},   {8'd255,8'd140,8'd0},   {8'd153,8'd50,8'd204},
    {8'd139,8'd0,8'd0},     {8'd233,8'd150,8'd122}, {8'd143,8'd188,8'd143},
    {8'd72,8'd61,8'd139},   {8'd47,8'd79,8'd79},    {8'd0,8'd206,8'd209},
    {8'd148,8'd0,8'd211},   {8'd255,8'd20,8'd147},  {8'd0,8'd191,8'd255},
    {8'd105,8'd105,8'd105}, {8'd30,8'd144,8'd255},  {8'd178,8'd34,8'd34},
    {8'd255,8'd250,8'd240}, {8'd34,8'd139,8'd34},   {8'd220,8'd220,8'd220},
    {8'd248,8'd248,8'd255}, {8'd255,8'd215,8'd0},   {8'd218,8'd165,8'd32},
    {8'd128,8'd128,8'd128}, {8'd0,8'd128,8'd0},     {8'd173,8'd255,8'd47},
    {8'd240,8'd255,8'd240}, {8'd255,8'd105,8'd180}, {8'd205,8'd92,8'd92},
    {8'd75,8'd0,8'd130},    {8'd255,8'd255,8'd240}, {8'd240,8'd230,8'd140},
    {8'd230,8'd230,8'd250}, {8'd255,8'd240,8'd245}, {8'd124,8'd252,8'd0},
    {8'd255,8'd250,8'd205}, {8'd173,8'd216,8'd230}, {8'd240,8'd128,8'd128},
    {8'd224,8'd255,8'd255}, {8'd238,8'd213,8'd160}, {8'd250,8'd250,8'd210},
    {8'd211,8'd211,8'd211}, {8'd144,8'd238,8'd144}, {8'd255,8'd182,8'd193},
    {8'd255,8'd160,8'd122}, {8'd32,8'd178,8'd170},  {8'd135,8'd206,8'd250},
    {8'd119,8'd136,8'd153}, {8'd176,8'd196,8'd222}, {8'd255,8'd255,8'd224},
    {8'd0,8'd255,8'd0},     {8'd50,8'd205,8'd50},   {8'd250,8'd240,8'd230},
    {8'd255,8'd0,8'd255},   {8'd128,8'd0,8'd0},     {8'd102,8'd205,8'd170},
    {8'd0,8'd0,8'd205},     {8'd186,8'd85,8'd211},  {8'd147,8'd112,8'd219},
    {8'd60,8'd179,8'd113},  {8'd123,8'd104,8'd238}, {8'd0,8'd250,8'd154},
    {8'd72,8'd209,8'd204},  {8'd199,8'd21,8'd133},  {8'd25,8'd25,8'd112},
    {8'd245,8'd255,8'd250}, {8'd255,8'd228,8'd225}, {8'd255,8'd228,8'd181},
    {8'd255,8'd222,8'd173}, {8'd0,8'd0,8'd128},     {8'd253,8'd245,8'd230},
    {8'd128,8'd128,8'd0},   {8'd107,8'd142,8'd35},  {8'd255,8'd165,8'd0},
    {8'd255,8'd69,8'd0},    {8'd218,8'd112,8'd214}, {8'd238,8'd232,8'd170},
    {8'd152,8'd251,8'd152}, {8'd175,8'd238,8'd238}, {8'd219,8'd112,8'd147},
    {8'd255,8'd239,8'd213}, {8'd255,8'd218,8'd185}, {8'd205,8'd133,8'd63},
    {8'd255,8'd192,8'd203}, {8'd221,8'd160,8'd221}, {8'd176,8'd224,8'd230},
    {8'd128,8'd0,8'd128},   {8'd102,8'd51,8'd153},  {8'd255,8'd0,8'd0},
    {8'd188,8'd143,8'd143}, {8'd65,8'd105,8'd225},  {8'd139,8'd69,8'd19},
    {8'd250,8'd128,8'd114}, {8'd244,8'd164,8'd96},  {8'd46,8'd139,8'd87},
    {8'd255,8'd245,8'd238}, {8'd160,8'd82,8'd45},   {8'd192,8'd192,8'd192},
    {8'd135,8'd206,8'd235}, {8'd106,8'd90,8'd205},  {8'd112,8'd128,8'd144},
    {8'd255,8'd250,8'd250}, {8'd0,8'd255,8'd127},   {8'd70,8'd130,8'd180},
    {8'd210,8'd180,8'd140}, {8'd0,8'd128,8'd128},   {8'd216,8'd191,8'd216},
    {8'd255,8'd99,8'd71},   {8'd64,8'd224,8'd208},  {8'd238,8'd130,8'd238},
    {8'd245,8'd222,8'd179}, {8'd255,8'd255,8'd255}, {8'd245,8'd245,8'd245},
    {8'd255,8'd255,8'd0},   {8'd154,8'd205,8'd50},  {8'd255,8'd128,8'd171}
  };

  function automatic logic [7:0] abs_diff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic longint unsigned q30_pow5(longint unsigned z);
    longint unsigned z2;
    longint unsigned z4;
    z2 = (z * z) >> 30;
    z4 = (z2 * z2) >> 30;
    return (z4 * z) >> 30;
  endfunction

  // Linearized sRGB value of code c in Q0.f, evaluated at elaboration.
  function automatic logic [31:0] lin_entry(int unsigned c, int unsigned f);
    longint unsigned v;
    longint unsigned n;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned y;
    longint unsigned maxv;
    maxv = (64'd1 << f) - 64'd1;
    if (c <= 10) begin
      v = (longint'(c) * 64'd10 * (64'd1 << f) + 64'd16473) / 64'd32946;
    end else begin
      n = 64'd1000 * longint'(c) + 64'd14025;
      t = (n * (64'd1 << 31) + 64'd269025) / 64'd538050;
      t2 = (t * t + (64'd1 << 29)) >> 30;
      lo = 64'd0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (q30_pow5(mid) <= t2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      y = (t2 * lo + (64'd1 << 29)) >> 30;
      v = (y + (64'd1 << (29 - f))) >> (30 - f);
    end
    if (v > maxv) begin
      v = maxv;
    end
    return v[31:0];
  endfunction

endpackage

>>> hw/rtl/nnc_ctrl.sv
// Controller for the nearest named color classifier: sequences load, palette
// scan, luminance steps and result hand-off. Depends on nnc_pkg.
`timescale 1ns / 1ps
`include "nearest_named_color_classifier_top_defines.svh"

module nnc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output nnc_pkg::nnc_cmd_t   cmd,
  input  nnc_pkg::nnc_status_t status
);
  import nnc_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, LUMA, DONE} state_t;

  state_t     state;
  logic [2:0] luma_cnt;

  assign in_ready     = (state == IDLE);
  assign cmd.load     = in_valid && (state == IDLE);
  assign cmd.scan     = (state == SCAN);
  assign cmd.luma     = (state == LUMA);
  assign cmd.luma_cnt = luma_cnt;
  assign cmd.out_load = (state == DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      luma_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (status.scan_last) begin
            state    <= LUMA;
            luma_cnt <= '0;
          end
        end
        LUMA: begin
          if (luma_cnt == LUMA_LAST) begin
            state    <= DONE;
            luma_cnt <= '0;
          end else begin
            luma_cnt <= luma_cnt + 3'd1;
          end
        end
        DONE: begin
          if (cmd.out_load) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `NNC_ASSERT_NEXT(a_load_starts_scan, clk, rst, cmd.load, state == SCAN, "load without scan")
  `NNC_ASSERT_NOW(a_out_load_free, clk, rst, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `NNC_ASSERT_NEXT(a_scan_end, clk, rst, cmd.scan && status.scan_last, state == LUMA, "scan did not end")
  `NNC_ASSERT_NOW(a_luma_bound, clk, rst, state == LUMA, luma_cnt <= LUMA_LAST, "luma step overrun")

endmodule

>>> hw/rtl/nnc_datapath.sv
// Datapath for the nearest named color classifier: configuration registers,
// palette distance scan, luminance accumulator and result word. Uses nnc_pkg.
`timescale 1ns / 1ps

module nnc_datapath #(
  parameter int PALETTE_ENTRIES = 141,
  parameter int LUMA_FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nnc_pkg::pixel_t      in_data,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  nnc_pkg::nnc_cmd_t    cmd,
  output nnc_pkg::nnc_status_t status,
  output nnc_pkg::result_t     out_data
);
  import nnc_pkg::*;

  localparam int F = LUMA_FRAC_BITS;
  localparam int SCAN_COUNT = (PALETTE_ENTRIES < ROM_DEPTH) ? PALETTE_ENTRIES : ROM_DEPTH;
  localparam logic [7:0] SCAN_LAST = 8'(SCAN_COUNT - 1);

  logic [7:0]  tolerance;
  logic [15:0] white_thr;
  logic [15:0] black_thr;

  pixel_t      pix;
  logic [7:0]  idx;
  logic [9:0]  best;
  logic [7:0]  best_idx;
  logic        found;

  logic [F-1:0]    lin_tab [256];
  logic [F-1:0]    lin_q;
  logic [15:0]     weight_q;
  logic [F+15:0]   prod;
  logic [F+15:0]   acc;

  for (genvar gi = 0; gi < 256; gi++) begin : g_lin
    localparam logic [F-1:0] LIN_VALUE = F'(lin_entry(gi, F));
    assign lin_tab[gi] = LIN_VALUE;
  end

  logic [23:0] pal;
  logic [9:0]  pal_dist;
  logic [9:0]  limit;
  logic [7:0]  lin_sel;
  logic [15:0] weight_sel;

  assign pal      = PALETTE_ROM[idx];
  assign pal_dist = 10'(abs_diff(pal[23:16], pix.red)) + 10'(abs_diff(pal[15:8], pix.green))
                  + 10'(abs_diff(pal[7:0], pix.blue));
  assign limit = 10'({2'b00, tolerance} * 10'd3) + 10'd1;
  assign status.scan_last = (idx == SCAN_LAST);

  always_comb begin
    case (cmd.luma_cnt)
      3'd0: begin
        lin_sel    = pix.red;
        weight_sel = W_RED;
      end
      3'd1: begin
        lin_sel    = pix.green;
        weight_sel = W_GREEN;
      end
      default: begin
        lin_sel    = pix.blue;
        weight_sel = W_BLUE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOLERANCE_RESET;
      white_thr <= WHITE_RESET;
      black_thr <= BLACK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOLERANCE: tolerance <= cfg_data[7:0];
        REG_WHITE:     white_thr <= cfg_data;
        REG_BLACK:     black_thr <= cfg_data;
        default:       tolerance <= tolerance;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix      <= in_data;
      idx      <= '0;
      best     <= limit;
      best_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.scan) begin
      idx <= idx + 8'd1;
      if (pal_dist < best) begin
        best     <= pal_dist;
        best_idx <= idx;
        found    <= 1'b1;
      end
    end
    if (cmd.luma) begin
      lin_q    <= lin_tab[lin_sel];
      weight_q <= weight_sel;
      prod     <= (F+16)'(weight_q * lin_q);
      if (cmd.luma_cnt == 3'd0) begin
        acc <= (F+16)'(1 << 15);
      end else if (cmd.luma_cnt >= 3'd2) begin
        acc <= acc + prod;
      end
    end
  end

  logic [F-1:0]  luma;
  logic [F+15:0] luma_scaled;
  logic [F+15:0] white_scaled;
  logic [F+15:0] black_scaled;
  logic [7:0]    mx;
  logic [7:0]    mn;
  logic [3:0]    dom;
  logic [3:0]    cls;

  assign luma         = acc[F+15:16];
  assign luma_scaled  = {luma, 16'd0};
  assign white_scaled = {white_thr, F'(0)};
  assign black_scaled = {black_thr, F'(0)};

  always_comb begin
    mx  = pix.red;
    mn  = pix.red;
    dom = 4'd0;
    if (pix.green > mx) begin
      mx  = pix.green;
      dom = 4'd1;
    end
    if (pix.blue > mx) begin
      mx  = pix.blue;
      dom = 4'd2;
    end
    if (pix.green < mn) begin
      mn = pix.green;
    end
    if (pix.blue < mn) begin
      mn = pix.blue;
    end
    if (luma_scaled > white_scaled) begin
      cls = CLS_WHITE;
    end else if (luma_scaled < black_scaled) begin
      cls = CLS_BLACK;
    end else if ({(mx - mn), 1'b0} > {1'b0, mx}) begin
      cls = CLS_STRONG_BASE + dom;
    end else begin
      cls = CLS_FAMILY_BASE + dom;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.matched        <= found;
      out_data.palette_index  <= found ? best_idx : 8'd0;
      out_data.best_distance  <= found ? best : 10'd0;
      out_data.fallback_class <= found ? CLS_MATCHED : cls;
    end
  end

endmodule

>>> hw/rtl/nearest_named_color_classifier_top.sv
// Each pixel word is handled in order: the controller takes the word, one palette
// entry is compared per cycle over the scanned palette (141 entries by default),
// the luminance is formed with one shared multiplier, and the result register is
// loaded once any earlier result has been taken.
// A new word is taken while a finished result waits; configuration is always ready.
// Top level of the nearest named color classifier; uses nnc_pkg, nnc_ctrl and
// nnc_datapath.
`timescale 1ns / 1ps

module nearest_named_color_classifier_top #(
  parameter int PALETTE_ENTRIES = 141,
  parameter int LUMA_FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  nnc_pkg::pixel_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output nnc_pkg::result_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import nnc_pkg::*;

  nnc_cmd_t    cmd;
  nnc_status_t status;

  assign cfg_ready = 1'b1;

  nnc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  nnc_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .LUMA_FRAC_BITS  (LUMA_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb.sv
// Testbench for the nearest named color classifier: drives pixel and register
// words, predicts each result word and checks it. Depends on nnc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import nnc_pkg::*;

  typedef struct {
    pixel_t     pix;
    logic [7:0] tol;
    bit         has_exp;
    result_t    exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pixel_t      in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_TOLERANCE;
  logic [15:0] cfg_data = '0;

  logic [15:0] lin_table [256];
  logic [7:0]  cur_tol;
  logic [15:0] cur_white;
  logic [15:0] cur_black;
  result_t     expected_q [$];
  dir_row_t    dir_rows [$];
  int          errors = 0;
  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          rx_cycle = 0;

  nearest_named_color_classifier_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint unsigned cube_free_pow5(longint unsigned z);
    longint unsigned sq;
    longint unsigned quad;
    sq = (z * z) >> 30;
    quad = (sq * sq) >> 30;
    return (quad * z) >> 30;
  endfunction

  function automatic logic [15:0] srgb_to_linear(int unsigned code);
    longint unsigned val;
    longint unsigned base;
    longint unsigned base_sq;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned prod;
    if (code <= 10) begin
      val = (longint'(code) * 10 * 65536 + 16473) / 32946;
    end else begin
      base = ((1000 * longint'(code) + 14025) * (64'd1 << 31) + 269025) / 538050;
      base_sq = (base * base + (64'd1 << 29)) >> 30;
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (cube_free_pow5(mid) <= base_sq) lo = mid;
        else hi = mid - 1;
      end
      prod = (base_sq * lo + (64'd1 << 29)) >> 30;
      val = (prod + (64'd1 << 13)) >> 14;
    end
    if (val > 65535) val = 65535;
    return val[15:0];
  endfunction

  function automatic result_t classify_pixel(pixel_t p);
    result_t         res;
    logic [23:0]     entry;
    int unsigned     l1_dist;
    int unsigned     best;
    longint unsigned acc;
    longint unsigned luma;
    logic [7:0]      mx;
    logic [7:0]      mn;
    logic [3:0]      dom;
    res = '0;
    best = 3 * cur_tol + 1;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      entry = PALETTE_ROM[i];
      l1_dist = ((entry[23:16] > p.red) ? entry[23:16] - p.red : p.red - entry[23:16])
              + ((entry[15:8] > p.green) ? entry[15:8] - p.green : p.green - entry[15:8])
              + ((entry[7:0] > p.blue) ? entry[7:0] - p.blue : p.blue - entry[7:0]);
      if (l1_dist < best) begin
        best = l1_dist;
        res.matched = 1'b1;
        res.palette_index = i[7:0];
        res.best_distance = l1_dist[9:0];
      end
    end
    if (res.matched) begin
      res.fallback_class = CLS_MATCHED;
      return res;
    end
    acc = longint'(W_RED) * lin_table[p.red] + longint'(W_GREEN) * lin_table[p.green]
        + longint'(W_BLUE) * lin_table[p.blue] + (64'd1 << 15);
    luma = acc >> 16;
    if (luma > cur_white) begin
      res.fallback_class = CLS_WHITE;
    end else if (luma < cur_black) begin
      res.fallback_class = CLS_BLACK;
    end else begin
      mx = p.red;
      mn = p.red;
      dom = 4'd0;
      if (p.green > mx) begin
        mx = p.green;
        dom = 4'd1;
      end
      if (p.blue > mx) begin
        mx = p.blue;
        dom = 4'd2;
      end
      if (p.green < mn) mn = p.green;
      if (p.blue < mn) mn = p.blue;
      res.fallback_class = ((9'(mx - mn) << 1) > 9'(mx)) ? CLS_STRONG_BASE + dom
                                                         : CLS_FAMILY_BASE + dom;
    end
    return res;
  endfunction

  // Output side: the stall pattern rotates through four modes, with long hold-offs on request.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle >> 7) % 4)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= $urandom_range(1);
        end
        2: begin
          out_ready <= ($urandom_range(3) == 0);
        end
        default: begin
          out_ready <= (rx_cycle % 8 != 0);
        end
      endcase
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%t unexpected word: actual %p", $time, out_data);
      end else begin
        if (out_data.matched !== expected_q[0].matched ||
            out_data.palette_index !== expected_q[0].palette_index ||
            out_data.best_distance !== expected_q[0].best_distance ||
            out_data.fallback_class !== expected_q[0].fallback_class) begin
          errors++;
          $display("%t mismatch: expected %p actual %p", $time, expected_q[0], out_data);
        end
        void'(expected_q.pop_front());
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TOLERANCE: cur_tol = val[7:0];
      REG_WHITE: cur_white = val;
      default: cur_black = val;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] tol, logic [15:0] white, logic [15:0] black);
    drain_results();
    write_reg(REG_TOLERANCE, {8'd0, tol});
    write_reg(REG_WHITE, white);
    write_reg(REG_BLACK, black);
  endtask

  task automatic send_pixel(pixel_t p, bit has_exp, result_t exp);
    int gap;
    result_t pred;
    in_data <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = classify_pixel(p);
    if (has_exp && pred != exp) begin
      errors++;
      $display("%t table row disagrees: expected %p predicted %p", $time, exp, pred);
    end
    expected_q.push_back(has_exp ? exp : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12);
      gap = $urandom_range(30, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    logic [23:0] entry;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        entry = PALETTE_ROM[$urandom_range(ROM_DEPTH - 1)];
        p.red = entry[23:16] + 8'($urandom_range(20)) - 8'd10;
        p.green = entry[15:8] + 8'($urandom_range(20)) - 8'd10;
        p.blue = entry[7:0] + 8'($urandom_range(20)) - 8'd10;
      end
      4: begin
        p.red = $urandom_range(1) ? 8'hff : 8'h00;
        p.green = $urandom_range(1) ? 8'hff : $urandom_range(255);
        p.blue = $urandom_range(1) ? 8'h00 : $urandom_range(255);
      end
      default: begin
        p = pixel_t'($urandom);
      end
    endcase
    return p;
  endfunction

  function automatic dir_row_t mk_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] tol, bit has_exp, result_t exp);
    dir_row_t row;
    row.pix = '{red: r, green: g, blue: b};
    row.tol = tol;
    row.has_exp = has_exp;
    row.exp = exp;
    return row;
  endfunction

  initial begin
    logic [7:0]  tol_set [8];
    logic [15:0] white_set [8];
    logic [15:0] black_set [8];
    for (int c = 0; c < 256; c++) lin_table[c] = srgb_to_linear(c);
    cur_tol = TOLERANCE_RESET;
    cur_white = WHITE_RESET;
    cur_black = BLACK_RESET;

    dir_rows.push_back(mk_row(0, 0, 0, 26, 1, '{1'b1, 8'd6, 10'd0, CLS_MATCHED}));
    dir_rows.push_back(mk_row(0, 0, 255, 26, 1, '{1'b1, 8'd8, 10'd0, CLS_MATCHED}));
    dir_rows.push_back(mk_row(255, 255, 255, 26, 0, '0));
    dir_rows.push_back(mk_row(255, 0, 255, 26, 0, '0));
    dir_rows.push_back(mk_row(90, 10, 250, 26, 0, '0));
    dir_rows.push_back(mk_row(1, 2, 3, 0, 1, '{1'b0, 8'd0, 10'd0, CLS_BLACK}));
    dir_rows.push_back(mk_row(254, 254, 254, 0, 0, '0));
    dir_rows.push_back(mk_row(255, 254, 255, 0, 0, '0));
    dir_rows.push_back(mk_row(200, 20, 20, 0, 0, '0));
    dir_rows.push_back(mk_row(20, 200, 20, 0, 0, '0));
    dir_rows.push_back(mk_row(20, 20, 200, 0, 0, '0));
    dir_rows.push_back(mk_row(150, 120, 110, 0, 0, '0));
    dir_rows.push_back(mk_row(100, 100, 100, 0, 0, '0));
    dir_rows.push_back(mk_row(130, 130, 60, 0, 0, '0));
    dir_rows.push_back(mk_row(60, 130, 130, 0, 0, '0));
    dir_rows.push_back(mk_row(0, 0, 1, 0, 0, '0));
    dir_rows.push_back(mk_row(0, 255, 1, 0, 0, '0));
    dir_rows.push_back(mk_row(77, 13, 201, 255, 0, '0));
    dir_rows.push_back(mk_row(0, 255, 255, 255, 0, '0));
    dir_rows.push_back(mk_row(128, 64, 32, 255, 0, '0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].tol != cur_tol) begin
        drain_results();
        write_reg(REG_TOLERANCE, {8'd0, dir_rows[i].tol});
      end
      send_pixel(dir_rows[i].pix, dir_rows[i].has_exp, dir_rows[i].exp);
    end

    tol_set = '{8'd26, 8'd0, 8'd255, 8'd0, 8'd0, 8'd5, 8'd12, 8'd40};
    white_set = '{16'd55706, 16'd55706, 16'd55706, 16'd0, 16'd65535,
                  16'd30000, 16'd40000, 16'd65535};
    black_set = '{16'd9830, 16'd9830, 16'd9830, 16'd0, 16'd65535,
                  16'd20000, 16'd5000, 16'd0};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6) begin
        tol_set[ph] = $urandom_range(255);
        white_set[ph] = $urandom_range(65535);
        black_set[ph] = $urandom_range(65535);
      end
      set_config(tol_set[ph], white_set[ph], black_set[ph]);
      for (int k = 0; k < 205; k++) begin
        if (k == 40 && (ph == 1 || ph == 5)) hold_req++;
        send_pixel(random_pixel(), 0, '0);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> nearest_named_color_classifier_top.f
+incdir+hw/rtl
hw/rtl/nnc_pkg.sv
hw/rtl/nnc_ctrl.sv
hw/rtl/nnc_datapath.sv
hw/rtl/nearest_named_color_classifier_top.sv
bench/tb.sv
